### rtl/utcx_pkg.sv
// utcx_pkg: shared types and constants for the utc extrapolate and step core
// depends on nothing; used by rtl/utc_extrapolate_and_step_core.sv
`default_nettype none

package utcx_pkg;

    localparam logic [31:0] STEP_THRESHOLD_RESET = 32'd5000000;

    localparam logic [1:0] MODE_DIRECT   = 2'd0;
    localparam logic [1:0] MODE_SCALED   = 2'd1;
    localparam logic [1:0] MODE_UNSCALED = 2'd2;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DIFF  = 12'b0000_0000_0010,
        S_MAG   = 12'b0000_0000_0100,
        S_CHK   = 12'b0000_0000_1000,
        S_DIV   = 12'b0000_0001_0000,
        S_SEL   = 12'b0000_0010_0000,
        S_MUL   = 12'b0000_0100_0000,
        S_NEG   = 12'b0000_1000_0000,
        S_EXP   = 12'b0001_0000_0000,
        S_DELTA = 12'b0010_0000_0000,
        S_MAGD  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } state_t;

endpackage

`default_nettype wire

### rtl/utc_extrapolate_and_step_core.sv
// utc_extrapolate_and_step_core: utc extrapolation from time reports and clock step decision
// bit-serial rate divider and ratio multiplier; depends on rtl/utcx_pkg.sv
`default_nettype none

// Each input transfer carries one utc report with its ptp stamp, the local ptp time, the local
// realtime clock and the sync flag; each one gives exactly one result transfer. The core keeps
// the previous report's utc and ptp stamps, forms the rate ratio with RATIO_FRAC_BITS fraction
// bits in a restoring divider that yields one quotient bit per cycle, and scales the ptp offset
// in a shift-add multiplier that takes one ratio bit per cycle. The core takes no new input
// transfer until the current item's result has been loaded into the output register, which
// waits for that register to empty. A finished result sits in the output register while the
// next input transfer is taken.
// step_threshold_ns is written through cfg_wr_en/cfg_wr_data.

module utc_extrapolate_and_step_core #(
    parameter int RATIO_FRAC_BITS = 30
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [31:0]  cfg_wr_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // report_utc_ns, report_ptp_ns, local_ptp_ns, local_realtime_ns
    input  wire logic [255:0] s_tdata,
    // report_valid, ptp_synced
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // expected_utc_ns, ptp_time_ns, step_offset_ns
    output logic [191:0]      m_tdata,
    // utc_valid, extrapolation_mode[1:0], step_request
    output logic [3:0]        m_tuser
);

    localparam int RW = RATIO_FRAC_BITS + 1;
    localparam int PW = 64 + RW;
    localparam int CW = $clog2(RATIO_FRAC_BITS + 2);
    localparam logic [RW-1:0] RATIO_ONE  = RW'(1) << RATIO_FRAC_BITS;
    localparam logic [RW-1:0] RATIO_HALF = RW'(1) << (RATIO_FRAC_BITS - 1);

    utcx_pkg::state_t state_reg, state_next;

    logic [31:0]   thr_reg, thr_next;
    logic [63:0]   last_utc_reg, last_utc_next;
    logic [63:0]   last_ptp_reg, last_ptp_next;

    logic [63:0]   rep_utc_reg, rep_utc_next;
    logic [63:0]   rep_ptp_reg, rep_ptp_next;
    logic [63:0]   loc_ptp_reg, loc_ptp_next;
    logic [63:0]   loc_rt_reg, loc_rt_next;
    logic          valid_in_reg, valid_in_next;
    logic          synced_reg, synced_next;

    logic [63:0]   du_reg, du_next;
    logic [63:0]   dp_reg, dp_next;
    logic [63:0]   d_reg, d_next;
    logic          unity_reg, unity_next;
    logic          direct_reg, direct_next;
    logic [63:0]   a_reg, a_next;
    logic [63:0]   b_reg, b_next;
    logic [63:0]   magd_reg, magd_next;
    logic          bad_reg, bad_next;
    logic          div_ok_reg, div_ok_next;
    logic [63:0]   r_reg, r_next;
    logic [RW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [63:0]   term_reg, term_next;
    logic [1:0]    mode_reg, mode_next;
    logic [63:0]   expected_reg, expected_next;
    logic [63:0]   delta_reg, delta_next;
    logic [63:0]   offs_reg, offs_next;
    logic [63:0]   magdelta_reg, magdelta_next;

    logic          m_valid_reg, m_valid_next;
    logic [191:0]  m_data_reg, m_data_next;
    logic [3:0]    m_user_reg, m_user_next;

    logic [63:0]   r_shift;
    logic [64:0]   mul_sum;
    logic [63:0]   p_trunc;
    logic          step_req;

    assign s_tready = (state_reg == utcx_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign r_shift  = {r_reg[62:0], 1'b0};
    assign mul_sum  = {1'b0, prod_reg[PW-1:RW]} + (prod_reg[0] ? {1'b0, magd_reg} : 65'd0);
    assign p_trunc  = prod_reg[RATIO_FRAC_BITS+63:RATIO_FRAC_BITS];
    assign step_req = (magdelta_reg > {32'd0, thr_reg});

    always_comb begin
        state_next    = state_reg;
        thr_next      = cfg_wr_en ? cfg_wr_data : thr_reg;
        last_utc_next = last_utc_reg;
        last_ptp_next = last_ptp_reg;
        rep_utc_next  = rep_utc_reg;
        rep_ptp_next  = rep_ptp_reg;
        loc_ptp_next  = loc_ptp_reg;
        loc_rt_next   = loc_rt_reg;
        valid_in_next = valid_in_reg;
        synced_next   = synced_reg;
        du_next       = du_reg;
        dp_next       = dp_reg;
        d_next        = d_reg;
        unity_next    = unity_reg;
        direct_next   = direct_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        magd_next     = magd_reg;
        bad_next      = bad_reg;
        div_ok_next   = div_ok_reg;
        r_next        = r_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        prod_next     = prod_reg;
        term_next     = term_reg;
        mode_next     = mode_reg;
        expected_next = expected_reg;
        delta_next    = delta_reg;
        offs_next     = offs_reg;
        magdelta_next = magdelta_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        unique case (state_reg)
            utcx_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    rep_utc_next  = s_tdata[63:0];
                    rep_ptp_next  = s_tdata[127:64];
                    loc_ptp_next  = s_tdata[191:128];
                    loc_rt_next   = s_tdata[255:192];
                    valid_in_next = s_tuser[0];
                    synced_next   = s_tuser[1];
                    state_next    = utcx_pkg::S_DIFF;
                end
            end
            utcx_pkg::S_DIFF: begin
                du_next       = rep_utc_reg - last_utc_reg;
                dp_next       = rep_ptp_reg - last_ptp_reg;
                d_next        = loc_ptp_reg - rep_ptp_reg;
                unity_next    = (last_utc_reg == 64'd0) || (rep_ptp_reg == last_ptp_reg);
                direct_next   = !synced_reg || (rep_ptp_reg == 64'd0);
                last_utc_next = rep_utc_reg;
                last_ptp_next = rep_ptp_reg;
                state_next    = utcx_pkg::S_MAG;
            end
            utcx_pkg::S_MAG: begin
                a_next     = du_reg[63] ? 64'd0 - du_reg : du_reg;
                b_next     = dp_reg[63] ? 64'd0 - dp_reg : dp_reg;
                magd_next  = d_reg[63] ? 64'd0 - d_reg : d_reg;
                bad_next   = (du_reg == 64'd0) || (du_reg[63] != dp_reg[63]);
                state_next = utcx_pkg::S_CHK;
            end
            utcx_pkg::S_CHK: begin
                div_ok_next = 1'b0;
                if (unity_reg) begin
                    q_next     = RATIO_ONE;
                    state_next = utcx_pkg::S_SEL;
                end else if (bad_reg || ({1'b0, a_reg} >= {b_reg, 1'b0})) begin
                    state_next = utcx_pkg::S_SEL;
                end else begin
                    div_ok_next = 1'b1;
                    if (a_reg >= b_reg) begin
                        q_next = RW'(1);
                        r_next = a_reg - b_reg;
                    end else begin
                        q_next = RW'(0);
                        r_next = a_reg;
                    end
                    cnt_next   = CW'(RATIO_FRAC_BITS - 1);
                    state_next = utcx_pkg::S_DIV;
                end
            end
            utcx_pkg::S_DIV: begin
                if (r_reg[63] || (r_shift >= b_reg)) begin
                    r_next = r_shift - b_reg;
                    q_next = {q_reg[RW-2:0], 1'b1};
                end else begin
                    r_next = r_shift;
                    q_next = {q_reg[RW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(0)) begin
                    state_next = utcx_pkg::S_SEL;
                end
            end
            utcx_pkg::S_SEL: begin
                if (direct_reg) begin
                    term_next  = 64'd0;
                    mode_next  = utcx_pkg::MODE_DIRECT;
                    state_next = utcx_pkg::S_EXP;
                end else if (unity_reg || (div_ok_reg && (q_reg > RATIO_HALF))) begin
                    prod_next  = {64'd0, q_reg};
                    cnt_next   = CW'(RATIO_FRAC_BITS);
                    mode_next  = utcx_pkg::MODE_SCALED;
                    state_next = utcx_pkg::S_MUL;
                end else begin
                    term_next  = d_reg;
                    mode_next  = utcx_pkg::MODE_UNSCALED;
                    state_next = utcx_pkg::S_EXP;
                end
            end
            utcx_pkg::S_MUL: begin
                prod_next = {mul_sum, prod_reg[RW-1:1]};
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == CW'(0)) begin
                    state_next = utcx_pkg::S_NEG;
                end
            end
            utcx_pkg::S_NEG: begin
                term_next  = d_reg[63] ? 64'd0 - p_trunc : p_trunc;
                state_next = utcx_pkg::S_EXP;
            end
            utcx_pkg::S_EXP: begin
                expected_next = rep_utc_reg + term_reg;
                state_next    = utcx_pkg::S_DELTA;
            end
            utcx_pkg::S_DELTA: begin
                delta_next = loc_rt_reg - expected_reg;
                offs_next  = expected_reg - loc_rt_reg;
                state_next = utcx_pkg::S_MAGD;
            end
            utcx_pkg::S_MAGD: begin
                magdelta_next = delta_reg[63] ? 64'd0 - delta_reg : delta_reg;
                state_next    = utcx_pkg::S_OUT;
            end
            utcx_pkg::S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(step_req ? offs_reg : 64'd0), loc_ptp_reg, expected_reg};
                    m_user_next  = {step_req, mode_reg, valid_in_reg};
                    state_next   = utcx_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = utcx_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= utcx_pkg::S_IDLE;
            thr_reg      <= utcx_pkg::STEP_THRESHOLD_RESET;
            last_utc_reg <= 64'd0;
            last_ptp_reg <= 64'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            thr_reg      <= thr_next;
            last_utc_reg <= last_utc_next;
            last_ptp_reg <= last_ptp_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rep_utc_reg  <= rep_utc_next;
        rep_ptp_reg  <= rep_ptp_next;
        loc_ptp_reg  <= loc_ptp_next;
        loc_rt_reg   <= loc_rt_next;
        valid_in_reg <= valid_in_next;
        synced_reg   <= synced_next;
        du_reg       <= du_next;
        dp_reg       <= dp_next;
        d_reg        <= d_next;
        unity_reg    <= unity_next;
        direct_reg   <= direct_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        magd_reg     <= magd_next;
        bad_reg      <= bad_next;
        div_ok_reg   <= div_ok_next;
        r_reg        <= r_next;
        q_reg        <= q_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
        term_reg     <= term_next;
        mode_reg     <= mode_next;
        expected_reg <= expected_next;
        delta_reg    <= delta_next;
        offs_reg     <= offs_next;
        magdelta_reg <= magdelta_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    // a new result appears only from the output state
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == utcx_pkg::S_OUT))
        else $error("result valid rose outside the output state");

    // an input transfer always starts the difference stage
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == utcx_pkg::S_DIFF))
        else $error("input transfer did not start processing");

    // no step request means a zero step offset
    a_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[3]) |-> (m_tdata[191:128] == 64'd0))
        else $error("step offset nonzero without step request");

    // mode code three is never produced
    a_mode_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[2:1] != 2'd3))
        else $error("illegal extrapolation mode");

endmodule

`default_nettype wire
